// File: src/mvm_pkg.sv
// Shared widths, command codes, state and control types for the matrix-vector multiplier.
package mvm_pkg;

  localparam int CMD_W  = 2;
  localparam int IDX_W  = 6;
  localparam int VAL_W  = 16;
  localparam int LEN_W  = 7;
  localparam int PROD_W = 32;
  localparam int SUM_W  = 38;

  localparam logic [LEN_W-1:0] LEN_RESET = 7'd64;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_WEIGHT = 2'd0,
    CMD_LOAD_INPUT  = 2'd1,
    CMD_COMPUTE     = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic             wr_weight;
    logic             wr_input;
    logic             acc_clr;
    logic             rd_en;
    logic             emit;
    logic             emit_last;
    logic [IDX_W-1:0] emit_row;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic pipe_busy;
  } dp_status_t;

endpackage

// File: src/mvm_in_if.sv
// Input word channel: command, indices and value.
interface mvm_in_if import mvm_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        cmd;
  logic [IDX_W-1:0]        row_index;
  logic [IDX_W-1:0]        col_index;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, output cmd, output row_index, output col_index,
                  output value, input ready);
  modport sink   (input valid, input cmd, input row_index, input col_index,
                  input value, output ready);
endinterface

// File: src/mvm_out_if.sv
// Result word channel: row index, dot product and last flag.
interface mvm_out_if import mvm_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [IDX_W-1:0]        result_row;
  logic signed [SUM_W-1:0] dot_sum;
  logic                    last;

  modport source (output valid, output result_row, output dot_sum, output last,
                  input ready);
  modport sink   (input valid, input result_row, input dot_sum, input last,
                  output ready);
endinterface

// File: src/mvm_cfg_if.sv
// Configuration write channel carrying the vector length register.
interface mvm_cfg_if import mvm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [LEN_W-1:0] vector_length;

  modport source (output valid, output vector_length, input ready);
  modport sink   (input valid, input vector_length, output ready);
endinterface

// File: src/matrix_vector_multiply.sv
// Matrix-vector multiply top level: length register, controller and datapath.
// Weight loads and vector element loads are written to memory as they are
// accepted. A compute word for an active length n is a sweep of n columns in
// which one column of weights and one vector element are read from memory and
// fed to a row of MAX_N multiply-accumulate cells, a drain of the read and
// multiply stages, then a shift of the n row sums out, one result word per
// cycle while the output is taken. New input words are accepted only
// between computations; the last result word may still be waiting when the
// next word is accepted. The vector length register may be written at any
// time the block is idle; 0 acts as 1 and values above MAX_N act as MAX_N.
module matrix_vector_multiply import mvm_pkg::*; #(
  parameter int MAX_N = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  mvm_cfg_if.sink      cfg_i,
  mvm_in_if.sink       in_i,
  mvm_out_if.source    out_o
);

  localparam int CNT_W  = $clog2(MAX_N + 1);
  localparam int ADDR_W = (MAX_N > 1) ? $clog2(MAX_N) : 1;
  localparam int WIDE_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

  logic [LEN_W-1:0]  len_q;
  logic [WIDE_W-1:0] len_wide;
  logic [CNT_W-1:0]  len_act;
  dp_cmd_t           dp_cmd;
  dp_status_t        dp_status;
  logic [ADDR_W-1:0] rd_addr;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= LEN_RESET;
    end else if (cfg_i.valid) begin
      len_q <= cfg_i.vector_length;
    end
  end

  assign len_wide = WIDE_W'(len_q);

  always_comb begin
    if (len_wide == '0) begin
      len_act = CNT_W'(1);
    end else if (len_wide > WIDE_W'(MAX_N)) begin
      len_act = CNT_W'(MAX_N);
    end else begin
      len_act = CNT_W'(len_wide);
    end
  end

  mvm_ctrl #(
    .MAX_N(MAX_N)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .len_i      (len_act),
    .in_valid_i (in_i.valid),
    .in_cmd_i   (in_i.cmd),
    .in_row_i   (in_i.row_index),
    .in_col_i   (in_i.col_index),
    .in_ready_o (in_i.ready),
    .status_i   (dp_status),
    .dp_cmd_o   (dp_cmd),
    .rd_addr_o  (rd_addr)
  );

  mvm_datapath #(
    .MAX_N(MAX_N)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (dp_cmd),
    .rd_addr_i   (rd_addr),
    .wr_row_i    (ADDR_W'(in_i.row_index)),
    .wr_col_i    (ADDR_W'(in_i.col_index)),
    .wr_value_i  (in_i.value),
    .status_o    (dp_status),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_row_o   (out_o.result_row),
    .out_sum_o   (out_o.dot_sum),
    .out_last_o  (out_o.last)
  );

endmodule

// File: src/mvm_ctrl.sv
// Controller: decodes input words and sequences the column sweep, drain and result emission.
module mvm_ctrl import mvm_pkg::*; #(
  parameter int MAX_N = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [$clog2(MAX_N+1)-1:0] len_i,
  input  logic                     in_valid_i,
  input  logic [CMD_W-1:0]         in_cmd_i,
  input  logic [IDX_W-1:0]         in_row_i,
  input  logic [IDX_W-1:0]         in_col_i,
  output logic                     in_ready_o,
  input  dp_status_t               status_i,
  output dp_cmd_t                  dp_cmd_o,
  output logic [((MAX_N > 1) ? $clog2(MAX_N) : 1)-1:0] rd_addr_o
);

  localparam int CNT_W  = $clog2(MAX_N + 1);
  localparam int ADDR_W = (MAX_N > 1) ? $clog2(MAX_N) : 1;
  localparam int CMP_W  = (CNT_W > IDX_W) ? CNT_W : IDX_W;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] n_q, n_d;
  logic [CNT_W-1:0] col_q, col_d;
  logic [CNT_W-1:0] row_q, row_d;
  logic             row_ok, col_ok;
  logic             col_end, row_end;

  assign row_ok  = CMP_W'(in_row_i) < CMP_W'(MAX_N);
  assign col_ok  = CMP_W'(in_col_i) < CMP_W'(MAX_N);
  assign col_end = (col_q == (n_q - CNT_W'(1)));
  assign row_end = (row_q == (n_q - CNT_W'(1)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      n_q     <= CNT_W'(1);
      col_q   <= '0;
      row_q   <= '0;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
      col_q   <= col_d;
      row_q   <= row_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && (in_cmd_i == CMD_COMPUTE)) state_d = ST_MAC;
      end
      ST_MAC: begin
        if (col_end) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!status_i.pipe_busy) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (status_i.out_free && row_end) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    dp_cmd_o   = '0;
    in_ready_o = 1'b0;
    n_d        = n_q;
    col_d      = col_q;
    row_d      = row_q;
    rd_addr_o  = ADDR_W'(col_q);
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        col_d      = '0;
        row_d      = '0;
        if (in_valid_i) begin
          // drop loads whose index falls outside the array
          if ((in_cmd_i == CMD_LOAD_WEIGHT) && row_ok && col_ok) dp_cmd_o.wr_weight = 1'b1;
          if ((in_cmd_i == CMD_LOAD_INPUT) && col_ok) dp_cmd_o.wr_input = 1'b1;
          if (in_cmd_i == CMD_COMPUTE) begin
            dp_cmd_o.acc_clr = 1'b1;
            n_d              = len_i;
          end
        end
      end
      ST_MAC: begin
        dp_cmd_o.rd_en = 1'b1;
        col_d          = col_q + CNT_W'(1);
      end
      ST_DRAIN: begin
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          dp_cmd_o.emit      = 1'b1;
          dp_cmd_o.emit_last = row_end;
          dp_cmd_o.emit_row  = IDX_W'(row_q);
          row_d              = row_q + CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// File: src/mvm_datapath.sv
// Datapath: weight and vector memories, a row of multiply-accumulate cells, result register.
module mvm_datapath import mvm_pkg::*; #(
  parameter int MAX_N = 64
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  dp_cmd_t                 cmd_i,
  input  logic [((MAX_N > 1) ? $clog2(MAX_N) : 1)-1:0] rd_addr_i,
  input  logic [((MAX_N > 1) ? $clog2(MAX_N) : 1)-1:0] wr_row_i,
  input  logic [((MAX_N > 1) ? $clog2(MAX_N) : 1)-1:0] wr_col_i,
  input  logic signed [VAL_W-1:0] wr_value_i,
  output dp_status_t              status_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [IDX_W-1:0]        out_row_o,
  output logic signed [SUM_W-1:0] out_sum_o,
  output logic                    out_last_o
);

  // Weight memory: one word per column, one lane per row.
  logic [MAX_N-1:0][VAL_W-1:0] w_mem [MAX_N];
  logic [VAL_W-1:0]            x_mem [MAX_N];

  logic [MAX_N-1:0][VAL_W-1:0] w_rd_q;
  logic signed [VAL_W-1:0]     x_rd_q;
  logic signed [PROD_W-1:0]    prod_q [MAX_N];
  logic signed [SUM_W-1:0]     acc_q  [MAX_N];
  logic                        rd_v_q, mul_v_q;

  logic                        out_valid_q;
  logic [IDX_W-1:0]            out_row_q;
  logic signed [SUM_W-1:0]     out_sum_q;
  logic                        out_last_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_weight) w_mem[wr_col_i][wr_row_i] <= wr_value_i;
    if (cmd_i.wr_input) x_mem[wr_col_i] <= wr_value_i;
    if (cmd_i.rd_en) begin
      w_rd_q <= w_mem[rd_addr_i];
      x_rd_q <= x_mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q  <= 1'b0;
      mul_v_q <= 1'b0;
    end else begin
      rd_v_q  <= cmd_i.rd_en;
      mul_v_q <= rd_v_q;
    end
  end

  for (genvar r = 0; r < MAX_N; r++) begin : g_cell
    logic signed [SUM_W-1:0] shift_in;

    if (r == MAX_N - 1) begin : g_tail
      assign shift_in = '0;
    end else begin : g_link
      assign shift_in = acc_q[r+1];
    end

    always_ff @(posedge clk_i) begin
      if (rd_v_q) prod_q[r] <= $signed(w_rd_q[r]) * x_rd_q;
      if (cmd_i.acc_clr) begin
        acc_q[r] <= '0;
      end else if (mul_v_q) begin
        acc_q[r] <= acc_q[r] + {{(SUM_W-PROD_W){prod_q[r][PROD_W-1]}}, prod_q[r]};
      end else if (cmd_i.emit) begin
        // advance the sums toward row zero, one per result word
        acc_q[r] <= shift_in;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_row_q  <= cmd_i.emit_row;
      out_sum_q  <= acc_q[0];
      out_last_q <= cmd_i.emit_last;
    end
  end

  assign status_o.out_free  = !out_valid_q || out_ready_i;
  assign status_o.pipe_busy = rd_v_q || mul_v_q;

  assign out_valid_o = out_valid_q;
  assign out_row_o   = out_row_q;
  assign out_sum_o   = out_sum_q;
  assign out_last_o  = out_last_q;

endmodule

// File: sim/matrix_vector_multiply_test.sv
// Testbench for the matrix-vector multiplier: directed and random word traffic checked against a predictor.
`timescale 1ns / 100ps

module matrix_vector_multiply_test;
  import mvm_pkg::*;

  localparam int MAX_N        = 64;
  localparam int DIR_LEN      = 8;
  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE_CYCLES = 2 * MAX_N + 8;
  localparam int STUCK_LIMIT  = 5000;
  localparam int SEG_WORDS    = 30;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [VAL_W-1:0] value;
  } mvm_word_t;

  typedef struct packed {
    logic [IDX_W-1:0]        row;
    logic signed [SUM_W-1:0] sum;
    logic                    last;
  } row_sum_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  mvm_cfg_if cfg_bus ();
  mvm_in_if  in_bus ();
  mvm_out_if out_bus ();

  matrix_vector_multiply dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  // Driven copies of the block's inputs, known from time zero
  logic             cfg_valid = 1'b0;
  logic [LEN_W-1:0] cfg_len   = '0;
  logic             word_valid = 1'b0;
  mvm_word_t        word_out   = '0;
  logic             res_ready  = 1'b0;

  assign cfg_bus.valid         = cfg_valid;
  assign cfg_bus.vector_length = cfg_len;
  assign in_bus.valid          = word_valid;
  assign in_bus.cmd            = word_out.cmd;
  assign in_bus.row_index      = word_out.row;
  assign in_bus.col_index      = word_out.col;
  assign in_bus.value          = word_out.value;
  assign out_bus.ready         = res_ready;

  wire in_fire  = word_valid && in_bus.ready;
  wire out_fire = out_bus.valid && res_ready;
  wire cfg_fire = cfg_valid && cfg_bus.ready;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Predictor state
  logic signed [VAL_W-1:0] weight_copy [MAX_N][MAX_N];
  logic signed [VAL_W-1:0] element_copy [MAX_N];
  logic [LEN_W-1:0]        len_reg = LEN_RESET;
  row_sum_t                expected_sums[$];

  // Stimulus state
  mvm_word_t   word_queue[$];
  bit          weight_set [MAX_N][MAX_N];
  bit          element_set [MAX_N];
  logic [LEN_W-1:0] stim_len = LEN_RESET;
  int unsigned queued_words = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  bit          hold_req = 1'b0;
  int          error_count = 0;

  function automatic int unsigned active_rows(input logic [LEN_W-1:0] raw);
    if (raw == 0) return 1;
    if (raw > MAX_N) return MAX_N;
    return 32'(raw);
  endfunction

  // Update the copy of the stores, or queue the row sums a compute word yields
  function automatic void apply_word(input mvm_word_t w);
    int unsigned n;
    longint      acc;
    row_sum_t    r;
    if (w.cmd == CMD_LOAD_WEIGHT) begin
      weight_copy[w.row][w.col] = w.value;
    end else if (w.cmd == CMD_LOAD_INPUT) begin
      element_copy[w.col] = w.value;
    end else if (w.cmd == CMD_COMPUTE) begin
      n = active_rows(len_reg);
      for (int i = 0; i < n; i++) begin
        acc = 0;
        for (int j = 0; j < n; j++)
          acc += longint'(element_copy[j]) * longint'(weight_copy[i][j]);
        r.row  = i[IDX_W-1:0];
        r.sum  = acc[SUM_W-1:0];
        r.last = (i == n - 1);
        expected_sums.push_back(r);
      end
    end
  endfunction

  // Driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_fire) apply_word(word_out);
      if (!word_valid || in_bus.ready) begin
        if (word_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          word_out   <= word_queue.pop_front();
          word_valid <= 1'b1;
        end else begin
          word_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor and result-side flow control
  bit hold_done = 1'b0;
  int hold_left = 0;

  always @(posedge clk_i) begin
    row_sum_t exp_sum;
    if (rst_ni) begin
      if (out_fire) begin
        if (expected_sums.size() == 0) begin
          $error("unexpected result word: result_row %0d dot_sum %0d last %0b",
                 out_bus.result_row, out_bus.dot_sum, out_bus.last);
          error_count++;
        end else begin
          exp_sum = expected_sums.pop_front();
          if (out_bus.result_row !== exp_sum.row) begin
            $error("result_row: expected %0d, got %0d", exp_sum.row, out_bus.result_row);
            error_count++;
          end
          if (out_bus.dot_sum !== exp_sum.sum) begin
            $error("dot_sum: expected %0d, got %0d", exp_sum.sum, out_bus.dot_sum);
            error_count++;
          end
          if (out_bus.last !== exp_sum.last) begin
            $error("last: expected %0b, got %0b", exp_sum.last, out_bus.last);
            error_count++;
          end
        end
      end
      if (hold_left > 0) begin
        res_ready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (hold_req && !hold_done) begin
        res_ready <= 1'b0;
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
      end else begin
        res_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: end the run when no word moves for too long
  int stuck_cycles = 0;

  always @(posedge clk_i) begin
    if (in_fire || out_fire || cfg_fire || !rst_ni) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Stimulus helpers, called on the falling edge
  function automatic logic [VAL_W-1:0] rand_value();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      default: return VAL_W'($urandom);
    endcase
  endfunction

  function automatic logic [IDX_W-1:0] pick_index(input int unsigned n);
    if ($urandom_range(9) < 8) return IDX_W'($urandom_range(n - 1, 0));
    return IDX_W'($urandom_range(MAX_N - 1, 0));
  endfunction

  function automatic void push_word(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] row,
                                    input logic [IDX_W-1:0] col, input logic [VAL_W-1:0] value);
    mvm_word_t w;
    w.cmd   = cmd;
    w.row   = row;
    w.col   = col;
    w.value = value;
    word_queue.push_back(w);
    if (cmd != CMD_UNUSED) queued_words++;
  endfunction

  function automatic void queue_weight(input int unsigned row, input int unsigned col,
                                       input logic [VAL_W-1:0] value);
    push_word(CMD_LOAD_WEIGHT, row[IDX_W-1:0], col[IDX_W-1:0], value);
    weight_set[row][col] = 1'b1;
  endfunction

  function automatic void queue_element(input int unsigned col, input logic [VAL_W-1:0] value);
    // row_index is don't-care here: toggle it anyway
    push_word(CMD_LOAD_INPUT, IDX_W'($urandom), col[IDX_W-1:0], value);
    element_set[col] = 1'b1;
  endfunction

  function automatic void queue_noise();
    push_word(CMD_UNUSED, IDX_W'($urandom), IDX_W'($urandom), VAL_W'($urandom));
  endfunction

  // Fill every entry the compute will read that was never written, then compute
  function automatic void queue_compute();
    int unsigned n;
    n = active_rows(stim_len);
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++)
        if (!weight_set[i][j]) queue_weight(i, j, rand_value());
    for (int j = 0; j < n; j++)
      if (!element_set[j]) queue_element(j, rand_value());
    push_word(CMD_COMPUTE, IDX_W'($urandom), IDX_W'($urandom), VAL_W'($urandom));
  endfunction

  function automatic void queue_traffic(input int unsigned count);
    int unsigned start;
    int unsigned n;
    int unsigned loads;
    int          pick;
    start = queued_words;
    n = active_rows(stim_len);
    while (queued_words - start < count) begin
      pick  = $urandom_range(99);
      loads = $urandom_range(5, 0);
      if (pick < 8) begin
        queue_noise();
      end else begin
        for (int k = 0; k < loads; k++) begin
          if ($urandom_range(1)) queue_weight(pick_index(n), pick_index(n), rand_value());
          else queue_element(pick_index(n), rand_value());
        end
        // drop the compute now and then: loads with no result
        if (pick >= 15) queue_compute();
      end
    end
  endfunction

  function automatic logic [LEN_W-1:0] pick_length();
    case ($urandom_range(9))
      0: return 7'd1;
      1: return LEN_W'(DIR_LEN);
      2: return 7'd0;
      default: return LEN_W'($urandom_range(DIR_LEN, 2));
    endcase
  endfunction

  task automatic settle();
    while (word_queue.size() > 0 || word_valid || expected_sums.size() > 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_length(input logic [LEN_W-1:0] len);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_len   <= len;
    do @(posedge clk_i); while (!cfg_bus.ready);
    cfg_valid <= 1'b0;
    len_reg  = len;
    stim_len = len;
    @(negedge clk_i);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    send_idle_pct = 16;
    recv_idle_pct = 80;

    // Largest magnitude sums in the first and last active rows
    write_length(LEN_W'(DIR_LEN));
    for (int j = 0; j < DIR_LEN; j++) begin
      queue_element(j, 16'h8000);
      queue_weight(0, j, 16'h8000);
      queue_weight(DIR_LEN - 1, j, 16'h7FFF);
    end
    queue_compute();
    queue_noise();
    queue_compute();
    settle();

    // Length 0 acts as 1
    write_length(7'd0);
    queue_weight(0, 0, 16'h8000);
    queue_compute();
    queue_weight(0, 0, 16'h7FFF);
    queue_element(0, 16'h7FFF);
    queue_compute();
    queue_weight(0, 0, 16'h0000);
    queue_compute();
    settle();

    write_length(7'd2);
    queue_weight(1, 0, 16'h8000);
    queue_element(1, 16'h0001);
    queue_compute();
    settle();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 16;
          recv_idle_pct = 80;
        end
        1: begin
          send_idle_pct = 80;
          recv_idle_pct = 16;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int seg = 0; seg < 4; seg++) begin
        if (phase == 2 && seg == 0) begin
          // Stall the result side while words keep coming
          write_length(LEN_W'(DIR_LEN));
          queue_traffic(SEG_WORDS);
          hold_req = 1'b1;
        end else begin
          write_length(pick_length());
          queue_traffic(SEG_WORDS);
        end
        settle();
      end
    end

    if (error_count == 0 && expected_sums.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: files.f
src/mvm_pkg.sv
src/mvm_in_if.sv
src/mvm_out_if.sv
src/mvm_cfg_if.sv
src/mvm_ctrl.sv
src/mvm_datapath.sv
src/matrix_vector_multiply.sv
sim/matrix_vector_multiply_test.sv
